// ----- rtl/casa_pkg.sv -----
// Shared types, register indexes and axis-order table for the cube axis swap address generator.
`timescale 1ns / 1ps
`default_nettype none

package casa_pkg;

   localparam int SIZE_W = 13;
   localparam int AXIS_W = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 13;
   localparam int ELEM_W = 32;
   localparam int INDEX_W = 36;
   localparam int ACC_W = 2 * SIZE_W + 1;
   localparam int PROD_W = ACC_W + SIZE_W;

   typedef logic [SIZE_W-1:0] size_type;
   typedef logic [AXIS_W-1:0] axis_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SIZE_X       = 3'd0,
      CSR_SIZE_Y       = 3'd1,
      CSR_SIZE_Z       = 3'd2,
      CSR_ORGANIZATION = 3'd3,
      CSR_SOURCE_AXIS  = 3'd4,
      CSR_TARGET_AXIS  = 3'd5,
      CSR_MIRROR       = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MUL1 = 3'b010,
      ST_MUL2 = 3'b100
   } state_type;

   localparam axis_type AXIS_ORDER [3][3] = '{
      '{2'd0, 2'd1, 2'd2},
      '{2'd0, 2'd2, 2'd1},
      '{2'd1, 2'd2, 2'd0}
   };

endpackage

`default_nettype wire

// ----- rtl/cube_axis_swap_scatter_address.sv -----
// Top level: position counters, axis swap and mirror, shared-multiplier index linearization.
// Flow: an accepted request word passes through states ST_MUL1 and ST_MUL2, then is registered
// as the result word once the output register is free; the single 27x13 multiplier makes two passes
// per word (z*size + y, then that times size + x), and a request is taken only when idle.
// A finished result waits in the output register while the next word is computed.
// Reset (synchronous, active high): counters zero, sizes 1, organization 0,
// source axis 0, target axis 1, mirror 0, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module cube_axis_swap_scatter_address
   import casa_pkg::*;
#(
   parameter int MAX_DIM = 4096,
   parameter int ELEMENT_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [ELEM_W-1:0]      req_element_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [INDEX_W-1:0]          rsp_dest_index,
   output logic [ELEM_W-1:0]           rsp_element_out,
   output logic                        rsp_last
);

   localparam int POS_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
   localparam logic [ELEM_W-1:0] ELEM_MASK = (ELEMENT_BITS >= ELEM_W) ? '1 :
      ELEM_W'((64'd1 << ELEMENT_BITS) - 64'd1);

   size_type  size_ff [3];
   size_type  size_in [3];
   axis_type  org_ff, org_in, src_ff, src_in, tgt_ff, tgt_in;
   logic      mirror_ff, mirror_in;

   logic [POS_W-1:0] pos_ff [3];
   logic [POS_W-1:0] pos_in [3];

   state_type state_ff, state_in;

   size_type          d_ff [3];
   size_type          d_in [3];
   size_type          os0_ff, os0_in, os1_ff, os1_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ELEM_W-1:0] elem_ff, elem_in;
   logic              last_ff, last_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [ELEM_W-1:0]  rsp_elem_ff, rsp_elem_in;
   logic               rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              load_rsp;
   size_type          eff_size [3];
   size_type          swap_size [3];
   size_type          d_eff [3];
   size_type          d_mir [3];
   logic [1:0]        row;
   axis_type          src_eff, tgt_eff, from_ax, to_ax;
   logic              end_x, end_y, end_z;
   logic [ACC_W-1:0]  mul_a;
   size_type          mul_b;
   logic [PROD_W-1:0] product;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign load_rsp = (state_ff == ST_MUL2) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (size_ff[i] == '0) begin
            eff_size[i] = SIZE_W'(1);
         end else if (32'(size_ff[i]) > MAX_DIM) begin
            eff_size[i] = SIZE_W'(MAX_DIM);
         end else begin
            eff_size[i] = size_ff[i];
         end
         d_eff[i] = (32'(pos_ff[i]) >= 32'(eff_size[i])) ? eff_size[i] - SIZE_W'(1) :
            SIZE_W'(pos_ff[i]);
      end
      row = (org_ff > 2'd2) ? 2'd0 : org_ff;
      src_eff = (src_ff > 2'd2) ? 2'd2 : src_ff;
      tgt_eff = (tgt_ff > 2'd2) ? 2'd2 : tgt_ff;
      from_ax = AXIS_ORDER[row][src_eff];
      to_ax = AXIS_ORDER[row][tgt_eff];

      swap_size = eff_size;
      swap_size[from_ax] = eff_size[to_ax];
      swap_size[to_ax] = eff_size[from_ax];

      d_mir = d_eff;
      if (mirror_ff) begin
         d_mir[from_ax] = eff_size[from_ax] - SIZE_W'(1) - d_eff[from_ax];
      end
      d_in = d_mir;
      d_in[from_ax] = d_mir[to_ax];
      d_in[to_ax] = d_mir[from_ax];

      end_x = (32'(pos_ff[0]) + 1) >= 32'(eff_size[0]);
      end_y = (32'(pos_ff[1]) + 1) >= 32'(eff_size[1]);
      end_z = (32'(pos_ff[2]) + 1) >= 32'(eff_size[2]);
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (!end_x) begin
            pos_in[0] = pos_ff[0] + POS_W'(1);
         end else begin
            pos_in[0] = '0;
            if (!end_y) begin
               pos_in[1] = pos_ff[1] + POS_W'(1);
            end else begin
               pos_in[1] = '0;
               pos_in[2] = end_z ? '0 : pos_ff[2] + POS_W'(1);
            end
         end
      end
   end

   always_comb begin
      size_in = size_ff;
      org_in = org_ff;
      src_in = src_ff;
      tgt_in = tgt_ff;
      mirror_in = mirror_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SIZE_X:       size_in[0] = csr_data;
            CSR_SIZE_Y:       size_in[1] = csr_data;
            CSR_SIZE_Z:       size_in[2] = csr_data;
            CSR_ORGANIZATION: org_in = csr_data[AXIS_W-1:0];
            CSR_SOURCE_AXIS:  src_in = csr_data[AXIS_W-1:0];
            CSR_TARGET_AXIS:  tgt_in = csr_data[AXIS_W-1:0];
            CSR_MIRROR:       mirror_in = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      mul_a = (state_ff == ST_MUL1) ? ACC_W'(d_ff[2]) : acc_ff;
      mul_b = (state_ff == ST_MUL1) ? os1_ff : os0_ff;
      product = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      state_in = state_ff;
      acc_in = acc_ff;
      os0_in = os0_ff;
      os1_in = os1_ff;
      elem_in = elem_ff;
      last_in = last_ff;
      rsp_index_in = rsp_index_ff;
      rsp_elem_in = rsp_elem_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               os0_in = swap_size[0];
               os1_in = swap_size[1];
               elem_in = req_element_value & ELEM_MASK;
               last_in = end_x && end_y && end_z;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            acc_in = product[ACC_W-1:0] + ACC_W'(d_ff[1]);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            if (load_rsp) begin
               rsp_index_in = product[INDEX_W-1:0] + INDEX_W'(d_ff[0]);
               rsp_elem_in = elem_ff;
               rsp_last_in = last_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pos_ff <= '{default: '0};
         size_ff <= '{default: SIZE_W'(1)};
         org_ff <= 2'd0;
         src_ff <= 2'd0;
         tgt_ff <= 2'd1;
         mirror_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff <= pos_in;
         size_ff <= size_in;
         org_ff <= org_in;
         src_ff <= src_in;
         tgt_ff <= tgt_in;
         mirror_ff <= mirror_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         d_ff <= d_in;
      end
      acc_ff <= acc_in;
      os0_ff <= os0_in;
      os1_ff <= os1_in;
      elem_ff <= elem_in;
      last_ff <= last_in;
      rsp_index_ff <= rsp_index_in;
      rsp_elem_ff <= rsp_elem_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_dest_index = rsp_index_ff;
   assign rsp_element_out = rsp_elem_ff;
   assign rsp_last = rsp_last_ff;

endmodule

`default_nettype wire

// ----- test/cube_axis_swap_scatter_address_tb.sv -----
// Self-checking testbench for the cube axis swap scatter address generator.
`timescale 1ns / 1ps

module cube_axis_swap_scatter_address_tb;
   import casa_pkg::*;

   localparam int MAX_DIM = 4096;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [INDEX_W-1:0] dest_index;
      logic [ELEM_W-1:0]  element;
      logic               last;
   } scatter_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [ELEM_W-1:0]      req_element_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [INDEX_W-1:0]     rsp_dest_index;
   logic [ELEM_W-1:0]      rsp_element_out;
   logic                   rsp_last;

   logic [SIZE_W-1:0]      cfg_size [3];
   logic [AXIS_W-1:0]      cfg_org;
   logic [AXIS_W-1:0]      cfg_src;
   logic [AXIS_W-1:0]      cfg_tgt;
   logic                   cfg_mirror;
   int unsigned            pos [3];

   scatter_word_type       scatter_expected [$];
   int                     error_count = 0;
   int                     cycle_count = 0;
   int                     send_idle_pct = 13;
   int                     recv_idle_pct = 48;

   cube_axis_swap_scatter_address u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_dest_index    (rsp_dest_index),
      .rsp_element_out   (rsp_element_out),
      .rsp_last          (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned eff_extent(input logic [SIZE_W-1:0] s);
      if (s == 0) return 1;
      if (s > MAX_DIM) return MAX_DIM;
      return 32'(s);
   endfunction

   function automatic scatter_word_type predict_scatter(input logic [ELEM_W-1:0] value);
      int unsigned      in_size [3];
      int unsigned      swap_size [3];
      int unsigned      d [3];
      int unsigned      row, from_ax, to_ax, t;
      logic [63:0]      lin;
      logic             end_x, end_y, end_z;
      scatter_word_type w;
      for (int i = 0; i < 3; i++) begin
         in_size[i] = eff_extent(cfg_size[i]);
         d[i] = (pos[i] >= in_size[i]) ? in_size[i] - 1 : pos[i];
      end
      row = (cfg_org > 2) ? 0 : cfg_org;
      from_ax = AXIS_ORDER[row][(cfg_src > 2) ? 2 : cfg_src];
      to_ax = AXIS_ORDER[row][(cfg_tgt > 2) ? 2 : cfg_tgt];
      swap_size = in_size;
      swap_size[from_ax] = in_size[to_ax];
      swap_size[to_ax] = in_size[from_ax];
      if (cfg_mirror) d[from_ax] = in_size[from_ax] - 1 - d[from_ax];
      t = d[from_ax];
      d[from_ax] = d[to_ax];
      d[to_ax] = t;
      lin = 64'(d[2]) * swap_size[1] + d[1];
      lin = lin * swap_size[0] + d[0];
      end_x = (pos[0] + 1 >= in_size[0]);
      end_y = (pos[1] + 1 >= in_size[1]);
      end_z = (pos[2] + 1 >= in_size[2]);
      w.dest_index = lin[INDEX_W-1:0];
      w.element = value;
      w.last = end_x && end_y && end_z;
      if (!end_x) begin
         pos[0]++;
      end else begin
         pos[0] = 0;
         if (!end_y) begin
            pos[1]++;
         end else begin
            pos[1] = 0;
            pos[2] = end_z ? 0 : pos[2] + 1;
         end
      end
      return w;
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR @%0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      case (idx)
         CSR_SIZE_X:       cfg_size[0] = data;
         CSR_SIZE_Y:       cfg_size[1] = data;
         CSR_SIZE_Z:       cfg_size[2] = data;
         CSR_ORGANIZATION: cfg_org = data[AXIS_W-1:0];
         CSR_SOURCE_AXIS:  cfg_src = data[AXIS_W-1:0];
         CSR_TARGET_AXIS:  cfg_tgt = data[AXIS_W-1:0];
         CSR_MIRROR:       cfg_mirror = data[0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (scatter_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] sx, sy, sz, org, src, tgt, mir);
      wait_drained();
      write_csr(CSR_SIZE_X, sx);
      write_csr(CSR_SIZE_Y, sy);
      write_csr(CSR_SIZE_Z, sz);
      write_csr(CSR_ORGANIZATION, org);
      write_csr(CSR_SOURCE_AXIS, src);
      write_csr(CSR_TARGET_AXIS, tgt);
      write_csr(CSR_MIRROR, mir);
      csr_write <= 1'b0;
   endtask

   task automatic send_word(input logic [ELEM_W-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_element_value <= value;
      do @(posedge clock); while (req_stall);
      scatter_expected.push_back(predict_scatter(value));
   endtask

   task automatic test_reset_defaults();
      send_word('0);
      send_word('1);
   endtask

   task automatic test_extreme_extents();
      set_geometry(13'h1FFF, 13'd4096, 13'd4096, 13'd0, 13'd0, 13'd2, 13'd1);
      send_word(32'hA5A5_5A5A);
      send_word($urandom);
      set_geometry(13'd0, 13'd4096, 13'd0, 13'd3, 13'd3, 13'd0, 13'd1);
      send_word($urandom);
   endtask

   task automatic test_axis_codes();
      for (int org = 0; org < 4; org++) begin
         set_geometry(13'd3, 13'd2, 13'd2, CSR_DATA_W'(org), CSR_DATA_W'(org),
                      CSR_DATA_W'(3 - org), CSR_DATA_W'(org % 2));
         send_word($urandom);
      end
   endtask

   task automatic test_same_axis();
      set_geometry(13'd2, 13'd3, 13'd2, 13'd1, 13'd1, 13'd1, 13'd1);
      send_word($urandom);
      send_word($urandom);
   endtask

   task automatic test_shrink_mid_cube();
      set_geometry(13'd4, 13'd4, 13'd4, 13'd0, 13'd1, 13'd2, 13'd1);
      repeat (6) send_word($urandom);
      wait_drained();
      write_csr(CSR_SIZE_X, 13'd2);
      write_csr(CSR_SIZE_Y, 13'd1);
      write_csr(CSR_UNUSED, 13'h1FFF);
      csr_write <= 1'b0;
      repeat (3) send_word($urandom);
   endtask

   task automatic test_cube_end();
      set_geometry(13'd2, 13'd1, 13'd2, 13'd2, 13'd0, 13'd1, 13'd0);
      repeat (4) send_word($urandom);
   endtask

   task automatic test_random_cubes(input int send_pct, input int recv_pct, input int words);
      int                    sent;
      int                    n;
      longint unsigned       vol;
      logic [CSR_DATA_W-1:0] extent;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < words) begin
         wait_drained();
         for (int i = 0; i < 3; i++) begin
            case ($urandom_range(15))
               0:       extent = '0;
               1:       extent = 13'd4096;
               2:       extent = CSR_DATA_W'($urandom_range(8191));
               3:       extent = '1;
               default: extent = CSR_DATA_W'($urandom_range(1, 5));
            endcase
            write_csr(CSR_INDEX_W'(int'(CSR_SIZE_X) + i), extent);
         end
         write_csr(CSR_ORGANIZATION, CSR_DATA_W'($urandom_range(8191)));
         write_csr(CSR_SOURCE_AXIS, CSR_DATA_W'($urandom_range(8191)));
         write_csr(CSR_TARGET_AXIS, CSR_DATA_W'($urandom_range(8191)));
         write_csr(CSR_MIRROR, CSR_DATA_W'($urandom_range(8191)));
         csr_write <= 1'b0;
         vol = longint'(eff_extent(cfg_size[0])) * eff_extent(cfg_size[1])
               * eff_extent(cfg_size[2]);
         n = (vol <= 48) ? int'(vol) * int'($urandom_range(1, 2))
                         : int'($urandom_range(1, 48));
         repeat (n) send_word($urandom);
         sent += n;
      end
   endtask

   always @(posedge clock) begin
      scatter_word_type want;
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (scatter_expected.size() == 0) begin
            report_error($sformatf("unexpected word, index %0h", rsp_dest_index));
         end else begin
            want = scatter_expected.pop_front();
            if (rsp_dest_index !== want.dest_index)
               report_error($sformatf("dest_index %0h, want %0h",
                                      rsp_dest_index, want.dest_index));
            if (rsp_element_out !== want.element)
               report_error($sformatf("element_out %0h, want %0h",
                                      rsp_element_out, want.element));
            if (rsp_last !== want.last)
               report_error($sformatf("last %0b, want %0b", rsp_last, want.last));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("cube_axis_swap_scatter_address verification failed");
      $finish;
   end

   initial begin
      cfg_size = '{13'd1, 13'd1, 13'd1};
      cfg_org = '0;
      cfg_src = '0;
      cfg_tgt = 2'd1;
      cfg_mirror = 1'b0;
      pos = '{0, 0, 0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_extreme_extents();
      test_axis_codes();
      test_same_axis();
      test_shrink_mid_cube();
      test_cube_end();
      test_random_cubes(13, 48, 660);
      test_random_cubes(48, 13, 660);
      test_random_cubes(0, 0, 660);
      wait_drained();
      repeat (10) @(posedge clock);
      if (scatter_expected.size() != 0)
         report_error($sformatf("%0d words never arrived", scatter_expected.size()));
      if (error_count == 0) begin
         $display("cube_axis_swap_scatter_address verification clean");
      end else begin
         $display("cube_axis_swap_scatter_address verification failed");
      end
      $finish;
   end

endmodule
